// File: sv/tdp_pkg.sv
package tdp_pkg;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture candidate, reset divisor to 3
        logic div_start;  // clear remainder and bit counter
        logic div_step;   // one restoring-division bit
        logic next_div;   // advance to the next odd divisor
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_neg;
        logic le_one;
        logic is_two;
        logic is_even;
        logic bound_over;  // divisor squared exceeds candidate
        logic cnt_last;    // current step is the last division bit
        logic rem_zero;
    } t_dp_status;

endpackage

// File: sv/trial_division_prime_test_unit.sv
// Channel   Handshake               Ports
// -------   ---------------------   ------------------------
// input     start & !busy           i_candidate
// result    o_valid, one cycle      o_is_prime
//
// One word at a time. A word is first classified; each odd trial divisor then takes a
// bound check, one bit per cycle in the restoring remainder unit, and a remainder
// check, so a worst-case odd prime n tries every odd divisor up to sqrt(n). busy
// is high from acceptance until the cycle the result strobes. Synchronous
// active-low reset returns to idle. The receiver cannot stall: o_valid lasts
// exactly one cycle, and o_is_prime holds until the next result.
module trial_division_prime_test_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [VALUE_WIDTH-1:0] i_candidate,
    output logic                          o_valid,
    output logic                          o_is_prime
);
    import tdp_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    tdp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd),
        .o_busy     (busy),
        .o_valid    (o_valid),
        .o_is_prime (o_is_prime)
    );

    tdp_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_value  (VALUE_WIDTH'(unsigned'(i_candidate))),
        .i_cmd    (dp_cmd),
        .o_status (dp_status)
    );

`ifndef SYNTHESIS
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_accept_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_valid_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a word in progress");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held two cycles");
`endif

endmodule

// File: sv/tdp_datapath.sv
module tdp_datapath #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  tdp_pkg::t_dp_cmd       i_cmd,
    output tdp_pkg::t_dp_status    o_status
);
    import tdp_pkg::*;

    localparam int CNT_W = $clog2(VALUE_WIDTH);

    logic [VALUE_WIDTH-1:0] r_n;
    logic [VALUE_WIDTH-1:0] r_d;
    logic [VALUE_WIDTH-1:0] r_sq;
    logic [VALUE_WIDTH-1:0] r_rem;
    logic [VALUE_WIDTH-1:0] r_shift;
    logic [CNT_W-1:0]       r_cnt;

    logic [VALUE_WIDTH:0]   trial;
    logic                   trial_ge;

    // shift in the next dividend bit, subtract if it fits
    assign trial    = {r_rem, r_shift[VALUE_WIDTH-1]};
    assign trial_ge = trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n  <= i_value;
            r_d  <= VALUE_WIDTH'(3);
            r_sq <= VALUE_WIDTH'(9);
        end else if (i_cmd.next_div) begin
            // (d+2)^2 = d^2 + 4d + 4
            r_d  <= r_d + VALUE_WIDTH'(2);
            r_sq <= r_sq + {r_d[VALUE_WIDTH-3:0], 2'b00} + VALUE_WIDTH'(4);
        end

        if (i_cmd.div_start) begin
            r_rem   <= '0;
            r_shift <= r_n;
            r_cnt   <= '0;
        end else if (i_cmd.div_step) begin
            if (trial_ge) begin
                r_rem <= VALUE_WIDTH'(trial - {1'b0, r_d});
            end else begin
                r_rem <= trial[VALUE_WIDTH-1:0];
            end
            r_shift <= {r_shift[VALUE_WIDTH-2:0], 1'b0};
            r_cnt   <= r_cnt + CNT_W'(1);
        end
    end

    always_comb begin
        o_status.is_neg     = r_n[VALUE_WIDTH-1];
        o_status.le_one     = (r_n[VALUE_WIDTH-1:1] == '0);
        o_status.is_two     = (r_n == VALUE_WIDTH'(2));
        o_status.is_even    = ~r_n[0];
        o_status.bound_over = (r_sq > r_n);
        o_status.cnt_last   = (r_cnt == CNT_W'(VALUE_WIDTH - 1));
        o_status.rem_zero   = (r_rem == '0);
    end

endmodule

// File: sv/tdp_ctrl.sv
module tdp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  tdp_pkg::t_dp_status i_status,
    output tdp_pkg::t_dp_cmd    o_cmd,
    output logic                o_busy,
    output logic                o_valid,
    output logic                o_is_prime
);
    import tdp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_BOUND,
        ST_DIVIDE,
        ST_CHECK_REM
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_valid;
    logic   r_is_prime;

    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = (r_state == ST_IDLE) && i_start;
        o_cmd.div_start = (r_state == ST_BOUND) && !i_status.bound_over;
        o_cmd.div_step  = (r_state == ST_DIVIDE);
        o_cmd.next_div  = (r_state == ST_CHECK_REM) && !i_status.rem_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_busy     <= 1'b0;
            r_valid    <= 1'b0;
            r_is_prime <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_state <= ST_CLASSIFY;
                        r_busy  <= 1'b1;
                    end
                end
                ST_CLASSIFY: begin
                    priority if (i_status.is_neg || i_status.le_one) begin
                        r_state    <= ST_IDLE;
                        r_busy     <= 1'b0;
                        r_valid    <= 1'b1;
                        r_is_prime <= 1'b0;
                    end else if (i_status.is_two) begin
                        r_state    <= ST_IDLE;
                        r_busy     <= 1'b0;
                        r_valid    <= 1'b1;
                        r_is_prime <= 1'b1;
                    end else if (i_status.is_even) begin
                        r_state    <= ST_IDLE;
                        r_busy     <= 1'b0;
                        r_valid    <= 1'b1;
                        r_is_prime <= 1'b0;
                    end else begin
                        r_state <= ST_BOUND;
                    end
                end
                ST_BOUND: begin
                    if (i_status.bound_over) begin
                        // no divisor up to the square root
                        r_state    <= ST_IDLE;
                        r_busy     <= 1'b0;
                        r_valid    <= 1'b1;
                        r_is_prime <= 1'b1;
                    end else begin
                        r_state <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE: begin
                    if (i_status.cnt_last) begin
                        r_state <= ST_CHECK_REM;
                    end
                end
                ST_CHECK_REM: begin
                    if (i_status.rem_zero) begin
                        r_state    <= ST_IDLE;
                        r_busy     <= 1'b0;
                        r_valid    <= 1'b1;
                        r_is_prime <= 1'b0;
                    end else begin
                        r_state <= ST_BOUND;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign o_busy     = r_busy;
    assign o_valid    = r_valid;
    assign o_is_prime = r_is_prime;

endmodule

// File: dv/trial_division_prime_test_unit_tb.sv
`timescale 1ns / 1ps

module trial_division_prime_test_unit_tb;

    import tdp_pkg::*;

    localparam int VALUE_WIDTH = 32;
    // slowest word is 2^31-1 (prime), which tries every odd divisor up to its square root
    localparam int unsigned CYCLE_LIMIT = 6_000_000;
    localparam int TAIL_CYCLES = 64;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_WORDS = 80;

    typedef struct {
        logic signed [VALUE_WIDTH-1:0] word;
        bit                            prime;
    } t_prime_verdict;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic signed [VALUE_WIDTH-1:0] i_candidate;
    logic                          o_valid;
    logic                          o_is_prime;

    t_prime_verdict pending_verdicts[$];
    int             mismatch_count = 0;
    int unsigned    cycle_count = 0;

    trial_division_prime_test_unit #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_candidate(i_candidate),
        .o_valid    (o_valid),
        .o_is_prime (o_is_prime)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic bit predict_is_prime(input logic signed [VALUE_WIDTH-1:0] word);
        logic [VALUE_WIDTH-1:0] raw;
        bit [63:0]              n;
        bit [63:0]              d;
        raw = word;
        n = 64'(raw);
        if (raw[VALUE_WIDTH-1])
            return 1'b0;
        if (n <= 1)
            return 1'b0;
        if (n == 2)
            return 1'b1;
        if (!n[0])
            return 1'b0;
        // d <= n/d keeps the bound free of overflow
        for (d = 3; d <= n / d; d += 2) begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void note_mismatch(input string what,
                                          input logic signed [VALUE_WIDTH-1:0] word,
                                          input bit exp_prime, input logic act_prime);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] %s: candidate %0d expected is_prime %0b, got %0b",
                     $realtime, what, word, exp_prime, act_prime);
    endfunction

    // results cannot be held off: take every strobe at the edge ending its cycle
    always @(posedge i_clk) begin
        t_prime_verdict v;
        if (i_rst_n && o_valid) begin
            if (pending_verdicts.size() == 0) begin
                note_mismatch("result with no word pending", '0, 1'b0, o_is_prime);
            end else begin
                v = pending_verdicts.pop_front();
                if (o_is_prime !== v.prime)
                    note_mismatch("wrong is_prime", v.word, v.prime, o_is_prime);
            end
        end
    end

    // start is left high on return so back-to-back words need no re-raise
    task automatic send_candidate(input logic signed [VALUE_WIDTH-1:0] word);
        t_prime_verdict v;
        start <= 1'b1;
        i_candidate <= word;
        do @(posedge i_clk); while (busy !== 1'b0);
        v.word = word;
        v.prime = predict_is_prime(word);
        pending_verdicts.push_back(v);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            i_candidate <= VALUE_WIDTH'($urandom);
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic wait_verdicts_drained();
        start <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 200);
    endfunction

    // mostly small magnitudes; large words are negative, even, or have a tiny factor
    function automatic logic signed [VALUE_WIDTH-1:0] random_candidate();
        int unsigned            r;
        int unsigned            p;
        logic [VALUE_WIDTH-1:0] m;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: m = $urandom_range(0, 2047);
            5, 6:          m = $urandom_range(2048, 65535);
            7:             m = {1'b1, 31'($urandom)};
            8:             m = {1'b0, 30'($urandom), 1'b0};
            default: begin
                r = $urandom_range(32'h0010_0000, 32'h7fff_ffff);
                p = 3 + 2 * $urandom_range(0, 5);
                m = (r / p) * p;
                if (!m[0])
                    m = m - p;
            end
        endcase
        return m;
    endfunction

    task automatic run_words(input logic signed [VALUE_WIDTH-1:0] words[]);
        foreach (words[k]) begin
            send_candidate(words[k]);
            if (k == words.size() - 1)
                wait_verdicts_drained();
            else
                idle_sender(random_gap());
        end
    endtask

    // sign bit, zero, one, two and even words settle without trial division
    task automatic test_classification();
        logic signed [VALUE_WIDTH-1:0] words[];
        words = '{32'sh8000_0000, -32'sd1, -32'sd3, 32'sd0, 32'sd1, 32'sd2, 32'sd4,
                  32'sd2147483646};
        run_words(words);
    endtask

    // odd words: squares of primes hit the bound exactly
    task automatic test_odd_divisors();
        logic signed [VALUE_WIDTH-1:0] words[];
        words = '{32'sd3, 32'sd5, 32'sd9, 32'sd15, 32'sd25, 32'sd49, 32'sd97, 32'sd121,
                  32'sd65521, 32'sd65535, 32'sd1018081};
        run_words(words);
    endtask

    // largest positive word is prime: full divisor sweep near the top of the range
    task automatic test_top_of_range();
        logic signed [VALUE_WIDTH-1:0] words[];
        words = '{32'sd2147483645, 32'sd2147483647};
        run_words(words);
    endtask

    task automatic test_random_words();
        int i;
        for (i = 0; i < RANDOM_WORDS; i++) begin
            send_candidate(random_candidate());
            if (i == RANDOM_WORDS - 1 || i == RANDOM_WORDS / 2)
                wait_verdicts_drained();
            else if ((i / 16) % 3 == 1)
                idle_sender(0);
            else
                idle_sender(random_gap());
        end
    endtask

    initial begin
        start <= 1'b0;
        i_candidate <= '0;
        i_rst_n <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_classification();
        test_odd_divisors();
        test_random_words();
        test_top_of_range();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        mismatch_count += pending_verdicts.size();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
